FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion wrappers used by the checker file gepe_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checked on every edge including reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked property, skipped while the disable condition holds
`define ASSERT_CLK_DIS(lbl, clk, dis, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) prop) else $error(msg);

`endif

FILE: rtl/core/gepe_pkg.sv
// ----------------------------------------------------------------------------
// gepe_pkg
// shared constants, types and the gf(256) multiply for the parity engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gepe_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] CFG_DATA_CNT   = 2'd0;
    localparam logic [1:0] CFG_PAR_CNT    = 2'd1;
    localparam logic [1:0] CFG_FIELD_POLY = 2'd2;
    localparam logic [1:0] CFG_CHECK_MODE = 2'd3;

    localparam logic [5:0] RST_DATA_CNT   = 6'd1;
    localparam logic [4:0] RST_PAR_CNT    = 5'd1;
    localparam logic [7:0] RST_FIELD_POLY = 8'd29;

    typedef struct packed {
        logic       en;
        logic [3:0] row;
        logic [7:0] value;
    } t_coef_wr;

    // carry-less multiply reduced by x^8 + poly
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] poly);
        logic [7:0] acc;
        logic [7:0] x;
        logic       carry;
        acc = '0;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            carry = x[7];
            x     = {x[6:0], 1'b0};
            if (carry) begin
                x = x ^ poly;
            end
        end
        return acc;
    endfunction

endpackage

FILE: rtl/core/gf256_erasure_parity_engine_top.sv
// ----------------------------------------------------------------------------
// gf256_erasure_parity_engine_top
// reed-solomon erasure parity generation and checking over gf(256)
// ----------------------------------------------------------------------------
// channel  | dir | handshake                       | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready   | tdata, tuser (opcode), tlast
// m_axis   | out | m_axis_tvalid / m_axis_tready   | tdata, tlast (last result)
// cfg      | in  | i_cfg_we, no back-pressure      | i_cfg_index, i_cfg_wdata
//
// one transaction per cycle in unless stalled; a data byte reaches the accumulators via the
// input register and the coefficient memory read at acceptance, then multiply and xor.
// the last data column in encode mode starts a burst of one result per active row, one
// per cycle from a snapshot bank unless the output stalls, while new transactions keep
// flowing. input stalls while an emitting byte meets an unfinished burst, or a check meets
// a burst or a stalled result; synchronous active-low reset, memory not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gf256_erasure_parity_engine_top #(
    parameter int MAX_DATA   = 32,
    parameter int MAX_PARITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row_index, column_index, value, zero fill
    input  logic [1:0]  s_axis_tuser,   // opcode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // parity_byte, parity_row, byte_mismatch,
                                        // block_mismatch, zero fill
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int LW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int DW = $clog2(MAX_DATA + 1);
    localparam int PW = $clog2(MAX_PARITY + 1);

    // configuration
    logic [5:0] r_data_cnt;
    logic [4:0] r_par_cnt;
    logic [7:0] r_field_poly;
    logic       r_check_mode;
    logic [DW-1:0] dn;
    logic [PW-1:0] pn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_cnt   <= gepe_pkg::RST_DATA_CNT;
            r_par_cnt    <= gepe_pkg::RST_PAR_CNT;
            r_field_poly <= gepe_pkg::RST_FIELD_POLY;
            r_check_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gepe_pkg::CFG_DATA_CNT:   r_data_cnt   <= i_cfg_wdata[5:0];
                gepe_pkg::CFG_PAR_CNT:    r_par_cnt    <= i_cfg_wdata[4:0];
                gepe_pkg::CFG_FIELD_POLY: r_field_poly <= i_cfg_wdata;
                gepe_pkg::CFG_CHECK_MODE: r_check_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_data_cnt == '0) begin
            dn = DW'(1);
        end else if (32'(r_data_cnt) > MAX_DATA) begin
            dn = DW'(MAX_DATA);
        end else begin
            dn = DW'(r_data_cnt);
        end
        if (r_par_cnt == '0) begin
            pn = PW'(1);
        end else if (32'(r_par_cnt) > MAX_PARITY) begin
            pn = PW'(MAX_PARITY);
        end else begin
            pn = PW'(r_par_cnt);
        end
    end

    // input unpack
    logic        a_accept;
    logic [1:0]  a_op;
    logic [3:0]  a_row;
    logic [4:0]  a_col;
    logic [7:0]  a_value;
    logic [31:0] a_col_wide;

    assign a_accept   = s_axis_tvalid & s_axis_tready;
    assign a_op       = s_axis_tuser;
    assign a_row      = s_axis_tdata[3:0];
    assign a_col      = s_axis_tdata[8:4];
    assign a_value    = s_axis_tdata[16:9];
    assign a_col_wide = 32'(a_col);

    // coefficient memory
    gepe_pkg::t_coef_wr     coef_wr;
    logic [MAX_PARITY-1:0][7:0] coef_row;

    always_comb begin
        coef_wr.en    = a_accept && (a_op == gepe_pkg::OP_LOAD)
                        && (32'(a_row) < MAX_PARITY) && (a_col_wide < MAX_DATA);
        coef_wr.row   = a_row;
        coef_wr.value = a_value;
    end

    gepe_coef_mem #(
        .DEPTH (MAX_DATA),
        .LANES (MAX_PARITY),
        .AW    (AW)
    ) u_coef_mem (
        .i_clk     (i_clk),
        .i_wr      (coef_wr),
        .i_wr_addr (a_col_wide[AW-1:0]),
        .i_rd_en   (a_accept),
        .i_rd_addr (a_col_wide[AW-1:0]),
        .o_rd_data (coef_row)
    );

    // second stage
    logic       r_b_valid;
    logic [1:0] r_b_op;
    logic [3:0] r_b_row;
    logic [4:0] r_b_col;
    logic [7:0] r_b_value;
    logic       r_b_lastpos;

    logic [7:0] r_acc  [MAX_PARITY];
    logic [7:0] n_acc  [MAX_PARITY];
    logic [7:0] r_snap [MAX_PARITY];
    logic       r_seen;

    logic          r_burst_active;
    logic [LW-1:0] r_burst_row;
    logic [LW-1:0] r_burst_last;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [3:0]    r_out_row;
    logic          r_out_bm;
    logic          r_out_blk;
    logic          r_out_last;

    logic          out_free;
    logic          burst_push;
    logic          burst_done;
    logic          b_is_data;
    logic          b_emit;
    logic          b_is_check;
    logic          b_hold;
    logic          b_adv;
    logic [31:0]   b_row_wide;
    logic [LW-1:0] b_lane;
    logic [7:0]    b_acc_sel;
    logic          b_bm;
    logic          b_blk;
    logic [LW-1:0] pn_last;
    logic [31:0]   burst_row_wide;

    assign out_free   = !r_out_valid || m_axis_tready;
    assign burst_push = r_burst_active && out_free;
    assign burst_done = burst_push && (r_burst_row == r_burst_last);

    assign b_is_data  = r_b_valid && (r_b_op == gepe_pkg::OP_DATA) && (32'(r_b_col) < 32'(dn));
    assign b_emit     = b_is_data && !r_check_mode && (32'(r_b_col) == 32'(dn) - 32'd1);
    assign b_is_check = r_b_valid && (r_b_op == gepe_pkg::OP_CHECK) && r_check_mode
                        && (32'(r_b_row) < 32'(pn));
    assign b_hold     = (b_emit && r_burst_active && !burst_done)
                        || (b_is_check && !(out_free && !r_burst_active));
    assign b_adv      = r_b_valid && !b_hold;
    assign s_axis_tready = !r_b_valid || !b_hold;

    assign b_row_wide = 32'(r_b_row);
    assign b_lane     = b_row_wide[LW-1:0];
    assign b_acc_sel  = r_acc[b_lane];
    assign b_bm       = (b_acc_sel != r_b_value);
    assign b_blk      = r_seen | b_bm;
    assign pn_last    = LW'(32'(pn) - 32'd1);
    assign burst_row_wide = 32'(r_burst_row);

    always_comb begin
        for (int l = 0; l < MAX_PARITY; l++) begin
            if (l < int'(pn)) begin
                if (r_b_col == '0) begin
                    n_acc[l] = gepe_pkg::gf_mul(coef_row[l], r_b_value, r_field_poly);
                end else begin
                    n_acc[l] = r_acc[l]
                               ^ gepe_pkg::gf_mul(coef_row[l], r_b_value, r_field_poly);
                end
            end else begin
                n_acc[l] = r_acc[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_b_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_accept) begin
            r_b_op      <= a_op;
            r_b_row     <= a_row;
            r_b_col     <= a_col;
            r_b_value   <= a_value;
            r_b_lastpos <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < MAX_PARITY; l++) begin
                r_acc[l] <= '0;
            end
            r_seen <= 1'b0;
        end else begin
            if (b_adv && b_is_data) begin
                r_acc <= n_acc;
            end
            if (b_adv && b_is_check) begin
                r_seen <= (r_b_lastpos && (b_lane == pn_last)) ? 1'b0 : b_blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv && b_emit) begin
            r_snap <= n_acc;
        end
    end

    // parity burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_active <= 1'b0;
        end else if (b_adv && b_emit) begin
            r_burst_active <= 1'b1;
        end else if (burst_done) begin
            r_burst_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv && b_emit) begin
            r_burst_row  <= '0;
            r_burst_last <= pn_last;
        end else if (burst_push) begin
            r_burst_row  <= r_burst_row + LW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (burst_push || (b_adv && b_is_check)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (burst_push) begin
            r_out_byte <= r_snap[r_burst_row];
            r_out_row  <= burst_row_wide[3:0];
            r_out_bm   <= 1'b0;
            r_out_blk  <= 1'b0;
            r_out_last <= (r_burst_row == r_burst_last);
        end else if (b_adv && b_is_check) begin
            r_out_byte <= b_acc_sel;
            r_out_row  <= r_b_row;
            r_out_bm   <= b_bm;
            r_out_blk  <= b_blk;
            r_out_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_blk, r_out_bm, r_out_row, r_out_byte};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: rtl/core/gepe_coef_mem.sv
// ----------------------------------------------------------------------------
// gepe_coef_mem
// coefficient store: one word per data column, one byte lane per parity row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gepe_coef_mem #(
    parameter int DEPTH = 32,
    parameter int LANES = 16,
    parameter int AW    = 5
) (
    input  logic                        i_clk,
    input  gepe_pkg::t_coef_wr          i_wr,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [LANES-1:0][7:0]       o_rd_data
);

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic [LANES-1:0][7:0] mem [DEPTH];
    logic [LANES-1:0][7:0] r_rd_data;
    logic [31:0]           wr_row_wide;
    logic [LW-1:0]         wr_lane;

    assign wr_row_wide = 32'(i_wr.row);
    assign wr_lane     = wr_row_wide[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr_addr][wr_lane] <= i_wr.value;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/gepe_checker.sv
// ----------------------------------------------------------------------------
// gepe_checker
// port-level checks on the parity engine result stream and on input ready after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gepe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result keeps its payload
    `ASSERT_CLK_DIS(a_out_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // reset empties the result register and opens the input
    `ASSERT_CLK(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")

    // a byte mismatch is always part of the block mismatch
    `ASSERT_CLK_DIS(a_blk_covers, i_clk, !i_rst_n, m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[13], "byte mismatch without block mismatch")

    // only encode bursts have non-final results, and they carry no flags
    `ASSERT_CLK_DIS(a_burst_flags, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[12] && !m_axis_tdata[13], "mismatch flag inside a parity burst")

endmodule

bind gf256_erasure_parity_engine_top gepe_checker u_gepe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
